@@ rtl/core/plg_pkg.sv @@
package plg_pkg;

   // Microcode step counter
   localparam int StepW = 4;
   typedef logic [StepW-1:0] step_type;

   // Step addresses of the control program
   localparam step_type StIdle     = 4'd0;
   localparam step_type StCheck    = 4'd1;
   localparam step_type StClear    = 4'd2;
   localparam step_type StBaseInit = 4'd3;
   localparam step_type StBaseTest = 4'd4;
   localparam step_type StBaseRead = 4'd5;
   localparam step_type StMark     = 4'd6;
   localparam step_type StBaseNext = 4'd7;
   localparam step_type StScanInit = 4'd8;
   localparam step_type StScanRead = 4'd9;
   localparam step_type StScanChk  = 4'd10;
   localparam step_type StFlush    = 4'd11;
   localparam step_type StEmpty    = 4'd12;

   // Datapath operation selected by a control word
   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_NOP,
      OP_CLEAR,
      OP_BASE_INIT,
      OP_BASE_TEST,
      OP_MULT_LOAD,
      OP_MARK,
      OP_BASE_INC,
      OP_SCAN_INIT,
      OP_SCAN_READ,
      OP_SCAN_CHK,
      OP_FLUSH,
      OP_EMPTY
   } op_type;

   // Jump condition of a control word
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_LIM_LT2,
      C_M_NE_LIM,
      C_PSQ_GT_LIM,
      C_COMPOSITE,
      C_M_LE_LIM,
      C_P_GT_LIM
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Control program: op, jump condition, jump target (else fall through)
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: StIdle};
      case (step)
         StIdle:     w = '{op: OP_ACCEPT,    cond: C_NEVER,      target: StIdle};
         StCheck:    w = '{op: OP_NOP,       cond: C_LIM_LT2,    target: StEmpty};
         StClear:    w = '{op: OP_CLEAR,     cond: C_M_NE_LIM,   target: StClear};
         StBaseInit: w = '{op: OP_BASE_INIT, cond: C_NEVER,      target: StIdle};
         StBaseTest: w = '{op: OP_BASE_TEST, cond: C_PSQ_GT_LIM, target: StScanInit};
         StBaseRead: w = '{op: OP_MULT_LOAD, cond: C_COMPOSITE,  target: StBaseNext};
         StMark:     w = '{op: OP_MARK,      cond: C_M_LE_LIM,   target: StMark};
         StBaseNext: w = '{op: OP_BASE_INC,  cond: C_ALWAYS,     target: StBaseTest};
         StScanInit: w = '{op: OP_SCAN_INIT, cond: C_NEVER,      target: StIdle};
         StScanRead: w = '{op: OP_SCAN_READ, cond: C_P_GT_LIM,   target: StFlush};
         StScanChk:  w = '{op: OP_SCAN_CHK,  cond: C_ALWAYS,     target: StScanRead};
         StFlush:    w = '{op: OP_FLUSH,     cond: C_ALWAYS,     target: StIdle};
         StEmpty:    w = '{op: OP_EMPTY,     cond: C_ALWAYS,     target: StIdle};
         default:    w = '{op: OP_NOP,       cond: C_ALWAYS,     target: StIdle};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/prime_list_generator.sv @@
// Prime list generator. One transfer on req_ carries a limit; the block
// answers with every prime from 2 up to min(limit, MAX_LIMIT) in ascending
// order, one rsp_ transfer each, rsp_is_last set on the final one. A limit
// below 2 gives one transfer with rsp_prime = 0 and both flags set. A short
// microcode program steps a sieve over a one-bit composite store with one
// write or read port: it clears flags 0 to limit, then for each base up to
// sqrt(limit) reads its flag and, if it is prime, marks each multiple from
// its square up to limit, then scans candidates from 2 in order; rsp_stall
// can hold the output register and so the scan. A new request is taken once
// the last result of the previous one is in the output register; that result
// may still be waiting.
module prime_list_generator #(
   parameter int MAX_LIMIT = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_limit,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_prime,
   output logic       rsp_is_last,
   output logic       rsp_empty_list
);

   localparam int AW = $clog2(MAX_LIMIT + 1);  // store address width
   localparam int MW = AW + 1;                 // base / multiple width

   // Composite flag store
   logic flags_mem [0:MAX_LIMIT];
   logic          mem_we;
   logic          mem_wdata;
   logic [AW-1:0] mem_waddr;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic          rd_flag_ff;

   // Sequencer
   plg_pkg::step_type      step_ff, step_in;
   plg_pkg::ctrl_word_type cw;
   logic                   hold;
   logic                   jump;

   // Datapath registers
   logic [AW-1:0]   lim_ff, lim_in;
   logic [MW-1:0]   p_ff, p_in;
   logic [MW-1:0]   m_ff, m_in;
   logic [7:0]      pend_ff, pend_in;
   logic            have_pend_ff, have_pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_prime_ff, rsp_prime_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_empty_ff, rsp_empty_in;

   logic [2*MW-1:0] psq;
   logic [MW-1:0]   lim_ext;
   logic            out_free;
   logic            is_prime;

   assign cw       = plg_pkg::ucode_rom(step_ff);
   assign lim_ext  = MW'(lim_ff);
   assign psq      = p_ff * p_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_prime = !rd_flag_ff;

   assign req_stall      = (step_ff != plg_pkg::StIdle);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime      = rsp_prime_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_empty_list = rsp_empty_ff;

   // Jump condition
   always_comb begin
      case (cw.cond)
         plg_pkg::C_NEVER:      jump = 1'b0;
         plg_pkg::C_ALWAYS:     jump = 1'b1;
         plg_pkg::C_LIM_LT2:    jump = (lim_ff < AW'(2));
         plg_pkg::C_M_NE_LIM:   jump = (m_ff != lim_ext);
         plg_pkg::C_PSQ_GT_LIM: jump = (psq > (2*MW)'(lim_ff));
         plg_pkg::C_COMPOSITE:  jump = rd_flag_ff;
         plg_pkg::C_M_LE_LIM:   jump = (m_ff <= lim_ext);
         plg_pkg::C_P_GT_LIM:   jump = (p_ff > lim_ext);
         default:               jump = 1'b0;
      endcase
   end

   // Datapath actions of the current control word
   always_comb begin
      hold         = 1'b0;
      lim_in       = lim_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      mem_we       = 1'b0;
      mem_wdata    = 1'b0;
      mem_waddr    = m_ff[AW-1:0];
      mem_re       = 1'b0;
      mem_raddr    = p_ff[AW-1:0];
      case (cw.op)
         plg_pkg::OP_ACCEPT: begin
            hold = !req_valid;
            if (int'(req_limit) > MAX_LIMIT) begin
               lim_in = AW'(MAX_LIMIT);
            end else begin
               lim_in = AW'(req_limit);
            end
            m_in = '0;
         end
         plg_pkg::OP_CLEAR: begin
            mem_we = 1'b1;
            m_in   = m_ff + MW'(1);
         end
         plg_pkg::OP_BASE_INIT: begin
            p_in = MW'(2);
         end
         plg_pkg::OP_BASE_TEST: begin
            mem_re = 1'b1;
         end
         plg_pkg::OP_MULT_LOAD: begin
            m_in = MW'(psq);
         end
         plg_pkg::OP_MARK: begin
            mem_we    = (m_ff <= lim_ext);
            mem_wdata = 1'b1;
            m_in      = m_ff + p_ff;
         end
         plg_pkg::OP_BASE_INC: begin
            p_in = p_ff + MW'(1);
         end
         plg_pkg::OP_SCAN_INIT: begin
            p_in         = MW'(2);
            have_pend_in = 1'b0;
         end
         plg_pkg::OP_SCAN_READ: begin
            mem_re = 1'b1;
         end
         plg_pkg::OP_SCAN_CHK: begin
            // a new prime releases the one held back, not yet known as last
            hold = is_prime && have_pend_ff && !out_free;
            if (!hold) begin
               if (is_prime) begin
                  if (have_pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_prime_in = pend_ff;
                     rsp_last_in  = 1'b0;
                     rsp_empty_in = 1'b0;
                  end
                  pend_in      = 8'(p_ff);
                  have_pend_in = 1'b1;
               end
               p_in = p_ff + MW'(1);
            end
         end
         plg_pkg::OP_FLUSH: begin
            hold = !out_free;
            if (!hold) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = pend_ff;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b0;
            end
         end
         plg_pkg::OP_EMPTY: begin
            hold = !out_free;
            if (!hold) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Next step
   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = cw.target;
      end else begin
         step_in = step_ff + plg_pkg::StepW'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= plg_pkg::StIdle;
         rsp_valid_ff <= 1'b0;
         have_pend_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         have_pend_ff <= have_pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      p_ff         <= p_in;
      m_ff         <= m_in;
      pend_ff      <= pend_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Flag store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flags_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_flag_ff <= flags_mem[mem_raddr];
      end
   end

endmodule
